FILE: hdl/glbp_pkg.sv
// shared types, constants and helper functions for the label box placer
`timescale 1ns / 1ps

package glbp_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int CFG_W         = 15;
    localparam int COORD_W       = 16;
    localparam int CFG_IDX_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP        = 2'd2;

    localparam logic [CFG_W-1:0] BOX_WIDTH_RST  = 15'd102;
    localparam logic [CFG_W-1:0] BOX_HEIGHT_RST = 15'd51;
    localparam logic [CFG_W-1:0] GAP_RST        = 15'd51;

    // candidate positions, bit 0 selects left, bit 1 selects bottom
    localparam logic [1:0] POS_TOP_RIGHT    = 2'd0;
    localparam logic [1:0] POS_TOP_LEFT     = 2'd1;
    localparam logic [1:0] POS_BOTTOM_RIGHT = 2'd2;
    localparam logic [1:0] POS_BOTTOM_LEFT  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [15:0]               label_tag;
        logic                      start_of_set;
    } in_beat_t;

    typedef struct packed {
        logic                      placed;
        logic [1:0]                position;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic [15:0]               out_tag;
        logic                      store_overflow;
    } out_beat_t;

    // store word layout: min_x in the low bits, max_y in the high bits
    typedef struct packed {
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_x;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic store_empty;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // closed boxes: touching edges count as a hit
    function automatic logic rect_meet(input rect_t a, input rect_t b);
        return (a.min_x <= b.max_x) && (b.min_x <= a.max_x) &&
               (a.min_y <= b.max_y) && (b.min_y <= a.max_y);
    endfunction

endpackage

FILE: hdl/greedy_label_box_placer.sv
// top level of the greedy four-position label box placer
`timescale 1ns / 1ps

// channel   signals                          beat
// -------   ------------------------------   ---------------------------------
// in        in_valid, in_ready, in_beat      one point with tag and set flag
// out       out_valid, out_ready, out_beat   one placement result per point
// cfg       cfg_we, cfg_index, cfg_data      one register write, no wait
//
// with boxes in the store, one stored box a cycle is read and tested against all
// four candidates, a drain state waits for the last read, then finish loads the
// result into the output register (an empty store goes from scan to finish)
// the sequencer returns to idle before the next point is taken
// reset clears the box count and restores the register defaults, never the store itself
// a stalled out channel holds the sequencer in finish; the next point may be
// accepted while a finished result still waits in the output register

module greedy_label_box_placer
    import glbp_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // point input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_beat,
    // placement result
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_beat
);

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: idle, scan store, drain last read, finish into output register
    glbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath holds registers, candidates, the box store and the result
    glbp_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

endmodule

FILE: hdl/glbp_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module glbp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/glbp_ctrl.sv
// sequencer: accept, scan the box store, then hand off the result
`timescale 1ns / 1ps

module glbp_ctrl
    import glbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.store_empty)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.rd_en = !stat.store_empty;
            end
            ST_DRAIN:
            begin
            end
            ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/glbp_dp.sv
// datapath: config registers, candidate boxes, box store, hit flags, result register
`timescale 1ns / 1ps

module glbp_dp
    import glbp_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  in_beat_t             in_beat,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_beat
);

    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BOXES);

    logic [CW-1:0]    box_count_reg;
    logic [CW-1:0]    box_count_next;
    logic [CW-1:0]    scan_idx_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] gap_reg;
    logic             rd_valid_reg;
    logic [3:0]       hits_reg;
    logic [15:0]      tag_reg;
    rect_t            cand_reg [4];
    rect_t            cand_next [4];
    logic signed [17:0] mx [4];
    logic signed [17:0] my [4];
    logic             out_valid_reg;
    out_beat_t        out_reg;
    out_beat_t        out_next;
    rect_t            stored;
    logic [RECT_W-1:0] ram_rdata;
    logic             found;
    logic [1:0]       pos;
    logic             full;
    logic             placed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= BOX_WIDTH_RST;
            height_reg <= BOX_HEIGHT_RST;
            gap_reg    <= GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOX_WIDTH:  width_reg  <= cfg_data;
                REG_BOX_HEIGHT: height_reg <= cfg_data;
                REG_GAP:        gap_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // four candidates, corners computed at 18 bits then saturated
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if ((k & 1) != 0)
            begin
                mx[k] = {{2{in_beat.point_x[15]}}, in_beat.point_x}
                        - {3'b000, gap_reg} - {3'b000, width_reg};
            end
            else
            begin
                mx[k] = {{2{in_beat.point_x[15]}}, in_beat.point_x} + {3'b000, gap_reg};
            end
            if ((k & 2) != 0)
            begin
                my[k] = {{2{in_beat.point_y[15]}}, in_beat.point_y}
                        - {3'b000, gap_reg} - {3'b000, height_reg};
            end
            else
            begin
                my[k] = {{2{in_beat.point_y[15]}}, in_beat.point_y} + {3'b000, gap_reg};
            end
            cand_next[k].min_x = sat16(mx[k]);
            cand_next[k].min_y = sat16(my[k]);
            cand_next[k].max_x = sat16(mx[k] + {3'b000, width_reg});
            cand_next[k].max_y = sat16(my[k] + {3'b000, height_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg <= in_beat.label_tag;
            for (int k = 0; k < 4; k++)
            begin
                cand_reg[k] <= cand_next[k];
            end
        end
    end

    // first free candidate wins
    always_comb
    begin
        found = 1'b0;
        pos   = POS_TOP_RIGHT;
        for (int k = 3; k >= 0; k--)
        begin
            if (!hits_reg[k])
            begin
                found = 1'b1;
                pos   = 2'(k);
            end
        end
    end

    assign full   = (box_count_reg == COUNT_MAX);
    assign placed = found && !full;

    always_comb
    begin
        box_count_next = box_count_reg;
        if (cmd.load && in_beat.start_of_set)
        begin
            box_count_next = '0;
        end
        else if (cmd.finish && placed)
        begin
            box_count_next = CW'(box_count_reg + CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg <= '0;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            hits_reg      <= '0;
        end
        else
        begin
            box_count_reg <= box_count_next;
            rd_valid_reg  <= cmd.rd_en;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                hits_reg     <= '0;
            end
            else
            begin
                if (cmd.rd_en)
                begin
                    scan_idx_reg <= CW'(scan_idx_reg + CW'(1));
                end
                if (rd_valid_reg)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        hits_reg[k] <= hits_reg[k] | rect_meet(cand_reg[k], stored);
                    end
                end
            end
        end
    end

    glbp_ram #(
        .WIDTH (RECT_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.finish && placed),
        .waddr (box_count_reg[AW-1:0]),
        .wdata (cand_reg[pos]),
        .re    (cmd.rd_en),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign stored = rect_t'(ram_rdata);

    always_comb
    begin
        out_next                = '0;
        out_next.out_tag        = tag_reg;
        out_next.placed         = placed;
        out_next.store_overflow = found && full;
        if (found)
        begin
            out_next.position  = pos;
            out_next.box_min_x = cand_reg[pos].min_x;
            out_next.box_min_y = cand_reg[pos].min_y;
            out_next.box_max_x = cand_reg[pos].max_x;
            out_next.box_max_y = cand_reg[pos].max_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_beat          = out_reg;
    assign stat.store_empty  = (box_count_reg == '0);
    assign stat.scan_last    = (scan_idx_reg == CW'(box_count_reg - CW'(1)));
    assign stat.out_free     = !out_valid_reg || out_ready;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        box_count_reg <= COUNT_MAX)
        else $error("box count beyond store depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (scan_idx_reg < box_count_reg))
        else $error("store read beyond filled entries");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && placed) |=> (box_count_reg == CW'($past(box_count_reg) + CW'(1))))
        else $error("placement did not append exactly one box");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.placed && out_reg.store_overflow))
        else $error("result both placed and overflowed");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

endmodule

FILE: tb/tb_greedy_label_box_placer.sv
// self-checking testbench for the greedy label box placer, directed and random points
`timescale 1ns / 1ps

module tb_greedy_label_box_placer;
    import glbp_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_POINTS = 800;
    // worst case is a full store: 64 boxes scanned between accept and result
    localparam int SETTLE_CYCLES = 80;
    // index 3 maps to no register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BOX_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_beat_t             in_beat   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_beat_t            out_beat;

    greedy_label_box_placer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    // local copy of the placer: stored boxes, box count and geometry registers
    int box_lo_x [MAX_BOXES_DEF];
    int box_lo_y [MAX_BOXES_DEF];
    int box_hi_x [MAX_BOXES_DEF];
    int box_hi_y [MAX_BOXES_DEF];
    int stored_boxes = 0;
    int width_q      = int'(BOX_WIDTH_RST);
    int height_q     = int'(BOX_HEIGHT_RST);
    int gap_q        = int'(GAP_RST);

    out_beat_t pending_results[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    // sender pacing and receiver hold-off
    int burst_left    = 0;
    bit sender_steady = 1'b0;
    int hold_request  = 0;
    int hold_left     = 0;
    int rx_phase      = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int clamp16(input int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    // closed boxes: a shared edge or corner is a hit
    function automatic bit hits_store(input int x0, input int y0, input int x1, input int y1);
        for (int i = 0; i < stored_boxes; i++)
        begin
            if (x0 <= box_hi_x[i] && box_lo_x[i] <= x1 && y0 <= box_hi_y[i] && box_lo_y[i] <= y1)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // first free candidate around the point, appended to the store when there is room
    function automatic out_beat_t predict_placement(input in_beat_t b);
        out_beat_t  r;
        int         px, py, mx, my, x0, y0, x1, y1;
        bit         found, left, below;
        logic [1:0] pos;
        r     = '0;
        found = 1'b0;
        px    = int'($signed(b.point_x));
        py    = int'($signed(b.point_y));
        r.out_tag = b.label_tag;
        if (b.start_of_set)
        begin
            stored_boxes = 0;
        end
        for (int k = 0; k < 4 && !found; k++)
        begin
            pos   = 2'(k);
            left  = (pos == POS_TOP_LEFT) || (pos == POS_BOTTOM_LEFT);
            below = (pos == POS_BOTTOM_RIGHT) || (pos == POS_BOTTOM_LEFT);
            mx = left ? px - gap_q - width_q : px + gap_q;
            my = below ? py - gap_q - height_q : py + gap_q;
            x0 = clamp16(mx);
            y0 = clamp16(my);
            x1 = clamp16(mx + width_q);
            y1 = clamp16(my + height_q);
            if (!hits_store(x0, y0, x1, y1))
            begin
                found       = 1'b1;
                r.position  = pos;
                r.box_min_x = x0[15:0];
                r.box_min_y = y0[15:0];
                r.box_max_x = x1[15:0];
                r.box_max_y = y1[15:0];
            end
        end
        if (found)
        begin
            if (stored_boxes < MAX_BOXES_DEF)
            begin
                box_lo_x[stored_boxes] = clamp16(int'($signed(r.box_min_x)));
                box_lo_y[stored_boxes] = clamp16(int'($signed(r.box_min_y)));
                box_hi_x[stored_boxes] = clamp16(int'($signed(r.box_max_x)));
                box_hi_y[stored_boxes] = clamp16(int'($signed(r.box_max_y)));
                stored_boxes++;
                r.placed = 1'b1;
            end
            else
            begin
                r.store_overflow = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got, input bit coord);
        if (want !== got)
        begin
            mismatch_count++;
            if (coord)
            begin
                $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            end
            else
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        end
    endtask

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            $error("result beat with no point pending, out_tag %0d", got.out_tag);
            return;
        end
        want = pending_results.pop_front();
        check_field("placed", want.placed, got.placed, 1'b0);
        check_field("position", want.position, got.position, 1'b0);
        check_field("box_min_x", want.box_min_x, got.box_min_x, 1'b1);
        check_field("box_min_y", want.box_min_y, got.box_min_y, 1'b1);
        check_field("box_max_x", want.box_max_x, got.box_max_x, 1'b1);
        check_field("box_max_y", want.box_max_y, got.box_max_y, 1'b1);
        check_field("out_tag", want.out_tag, got.out_tag, 1'b0);
        check_field("store_overflow", want.store_overflow, got.store_overflow, 1'b0);
    endtask

    // receiver stall pattern, cycling through four styles as the phase advances
    function automatic bit ready_pattern(input int phase);
        unique case ((phase / 300) % 4)
            0: return 1'b1;
            1: return $urandom_range(0, 1) != 0;
            2: return (phase % 7) < 3;
            default: return $urandom_range(0, 9) != 0;
        endcase
    endfunction

    // result side: check each accepted beat, then pick ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_result(out_beat);
        end
        rx_phase++;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ready_pattern(rx_phase);
        end
    end

    function automatic in_beat_t make_point(input int x, input int y, input int tag, input bit start);
        in_beat_t b;
        b.point_x      = x[15:0];
        b.point_y      = y[15:0];
        b.label_tag    = tag[15:0];
        b.start_of_set = start;
        return b;
    endfunction

    // bursts of back-to-back beats, then a random gap with valid low
    task automatic pace_sender();
        int idle;
        if (sender_steady)
        begin
            return;
        end
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        idle = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
    endtask

    task automatic send_point(input in_beat_t b);
        in_beat  <= b;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_results.insert(pending_results.size(), predict_placement(b));
        pace_sender();
    endtask

    // block idle: no point offered and every result returned
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // one write per edge; the caller lowers the enable after the last one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        unique case (idx)
            REG_BOX_WIDTH:  width_q  = int'(value);
            REG_BOX_HEIGHT: height_q = int'(value);
            REG_GAP:        gap_q    = int'(value);
            default: ;
        endcase
    endtask

    task automatic program_geometry(input int w, input int h, input int g);
        wait_quiet();
        cfg_write(REG_BOX_WIDTH, w[CFG_W-1:0]);
        cfg_write(REG_BOX_HEIGHT, h[CFG_W-1:0]);
        cfg_write(REG_GAP, g[CFG_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    // same point five times: all four positions, then nothing free
    task automatic test_four_positions();
        send_point(make_point(0, 0, 16'hffff, 1'b1));
        for (int i = 1; i <= 4; i++)
        begin
            send_point(make_point(0, 0, i, 1'b0));
        end
    endtask

    // boxes that share an edge collide, one step further they do not
    task automatic test_touching_edges();
        send_point(make_point(0, 0, 16'h0010, 1'b1));
        send_point(make_point(102, 0, 16'h0011, 1'b0));
        send_point(make_point(103, 0, 16'h0012, 1'b0));
        send_point(make_point(0, 51, 16'h0013, 1'b0));
        send_point(make_point(0, 52, 16'h0014, 1'b0));
    endtask

    // corners of the coordinate range push candidate corners into saturation
    task automatic test_saturation();
        send_point(make_point(32767, 32767, 16'h8000, 1'b1));
        send_point(make_point(-32768, -32768, 16'h8001, 1'b0));
        send_point(make_point(32767, -32768, 16'h8002, 1'b0));
        send_point(make_point(-32768, 32767, 16'h8003, 1'b0));
    endtask

    task automatic test_register_extremes();
        program_geometry(1, 1, 0);
        send_point(make_point(0, 0, 16'h0100, 1'b1));
        send_point(make_point(0, 0, 16'h0101, 1'b0));
        // zero-sized boxes are points, still hit on equality
        program_geometry(0, 0, 0);
        send_point(make_point(5, 5, 16'h0200, 1'b1));
        send_point(make_point(5, 5, 16'h0201, 1'b0));
        send_point(make_point(6, 5, 16'h0202, 1'b0));
        program_geometry(32767, 32767, 32767);
        send_point(make_point(0, 0, 16'h0300, 1'b1));
        send_point(make_point(-32768, -32768, 16'h0301, 1'b0));
        send_point(make_point(32767, 0, 16'h0302, 1'b0));
        // write to the unmapped index must leave the geometry alone
        wait_quiet();
        cfg_write(REG_BOX_WIDTH, 15'd1);
        cfg_write(REG_BOX_HEIGHT, 15'd1);
        cfg_write(REG_GAP, 15'd0);
        cfg_write(REG_UNMAPPED, 15'h7fff);
        cfg_we <= 1'b0;
        send_point(make_point(100, 100, 16'h0400, 1'b1));
        send_point(make_point(100, 100, 16'h0401, 1'b0));
        program_geometry(int'(BOX_WIDTH_RST), int'(BOX_HEIGHT_RST), int'(GAP_RST));
    endtask

    // fill all entries, then free candidates report overflow, then a fresh set
    task automatic test_full_store();
        program_geometry(1, 1, 0);
        send_point(make_point(0, 0, 16'h0500, 1'b1));
        for (int i = 1; i < MAX_BOXES_DEF + 6; i++)
        begin
            send_point(make_point(i * 16, 0, 16'h0500 + i, 1'b0));
        end
        // every candidate around the first point touches its stored box
        send_point(make_point(0, 0, 16'h05f0, 1'b0));
        send_point(make_point(-5000, -5000, 16'h05f1, 1'b0));
        send_point(make_point(0, 0, 16'h05f2, 1'b1));
    endtask

    task automatic random_geometry();
        int kind;
        int w, h, g;
        kind = $urandom_range(0, 5);
        if (kind < 3)
        begin
            w = $urandom_range(1, 300);
            h = $urandom_range(1, 300);
            g = $urandom_range(0, 100);
        end
        else if (kind == 3)
        begin
            w = $urandom_range(0, 32767);
            h = $urandom_range(0, 32767);
            g = $urandom_range(0, 32767);
        end
        else
        begin
            w = ($urandom_range(0, 1) != 0) ? 32767 : $urandom_range(0, 1);
            h = ($urandom_range(0, 1) != 0) ? 32767 : $urandom_range(0, 1);
            g = ($urandom_range(0, 1) != 0) ? 32767 : 0;
        end
        program_geometry(w, h, g);
    endtask

    // sets of points: clustered sets force collisions, spread sets fill the store
    task automatic test_random_sets();
        int       sent, set_len, span, cx, cy;
        bit       clustered;
        in_beat_t b;
        sent = 0;
        while (sent < RANDOM_POINTS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                random_geometry();
            end
            set_len       = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90)
                                                        : $urandom_range(1, 30);
            clustered     = $urandom_range(0, 2) != 0;
            span          = $urandom_range(50, 600);
            cx            = int'($urandom_range(0, 65535)) - 32768;
            cy            = int'($urandom_range(0, 65535)) - 32768;
            sender_steady = $urandom_range(0, 4) == 0;
            for (int i = 0; i < set_len; i++)
            begin
                if (clustered)
                begin
                    b.point_x = 16'(clamp16(cx + int'($urandom_range(0, 2 * span)) - span));
                    b.point_y = 16'(clamp16(cy + int'($urandom_range(0, 2 * span)) - span));
                end
                else
                begin
                    b.point_x = 16'($urandom);
                    b.point_y = 16'($urandom);
                end
                b.label_tag = 16'($urandom);
                // a stray start in mid-set breaks the sequence now and then
                b.start_of_set = (i == 0) || ($urandom_range(0, 40) == 0);
                send_point(b);
                sent++;
            end
        end
        sender_steady = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so in_ready must drop
    task automatic test_backpressure();
        in_beat_t b;
        wait_quiet();
        hold_request  = 500;
        sender_steady = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            b.point_x      = 16'($urandom);
            b.point_y      = 16'($urandom);
            b.label_tag    = 16'($urandom);
            b.start_of_set = (i == 0);
            send_point(b);
        end
        sender_steady = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_four_positions();
        test_touching_edges();
        test_saturation();
        test_register_extremes();
        test_full_store();
        test_backpressure();
        test_random_sets();
        test_backpressure();
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
